// ===== rtl/bfd_pkg.sv =====
// Shared types and constants for the BFD session liveness monitor.
// No dependencies; every other file imports this package.
package bfd_pkg;

    typedef enum logic [1:0] {
        ST_ADMIN = 2'd0,
        ST_DOWN  = 2'd1,
        ST_INIT  = 2'd2,
        ST_UP    = 2'd3
    } sess_state_t;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_SHORT    = 2'd1,
        KIND_RANGE    = 2'd2,
        KIND_TICK     = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_PKT,
        CTL_TICK
    } ctl_state_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PORTS_IN_USE = 3'd0,
        REG_LOCAL_DISC   = 3'd1,
        REG_PASSIVE_MASK = 3'd2,
        REG_TIMEOUT      = 3'd3,
        REG_SLOW_RATIO   = 3'd4
    } cfg_reg_t;

    localparam int TIME_W = 48;
    localparam int MASK_W = 8;

    localparam logic [15:0] MIN_UDP_LEN = 16'd24;

    localparam logic [3:0]  PORTS_IN_USE_RST = 4'd8;
    localparam logic [31:0] TIMEOUT_RST      = 32'd3000;
    localparam logic [15:0] SLOW_RATIO_RST   = 16'd10;

    // Controller to datapath
    typedef struct packed {
        logic load;   // latch the incoming item, rewind the port walk
        logic emit;   // commit one port update and fill the result register
    } bfd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic new_tick;  // incoming item is a checkpoint tick
        logic at_last;   // port walk sits on the highest port in use
    } bfd_sts_t;

endpackage

// ===== rtl/bfd_if.sv =====
// Valid/ready channel interfaces: input items, result items, configuration writes.
// Depends on bfd_pkg for the configuration widths.
interface bfd_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  port;
    logic [47:0] now_us;
    logic [31:0] peer_discriminator;
    logic [7:0]  vers_and_diag;
    logic [15:0] udp_length;
    logic [7:0]  link_down_mask;

    modport source (output valid, op, port, now_us, peer_discriminator, vers_and_diag,
                    udp_length, link_down_mask, input ready);
    modport sink (input valid, op, port, now_us, peer_discriminator, vers_and_diag,
                  udp_length, link_down_mask, output ready);
endinterface

interface bfd_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_port;
    logic [1:0]  kind;
    logic        send_echo;
    logic        went_down;
    logic [1:0]  self_state;
    logic [1:0]  peer_state;
    logic [31:0] remote_id;
    logic [31:0] change_count;
    logic        last;

    modport source (output valid, out_port, kind, send_echo, went_down, self_state,
                    peer_state, remote_id, change_count, last, input ready);
    modport sink (input valid, out_port, kind, send_echo, went_down, self_state,
                  peer_state, remote_id, change_count, last, output ready);
endinterface

interface bfd_cfg_if
    import bfd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bfd_ctrl.sv =====
// Controller state machine: input handshake, port walk sequencing, result valid.
// Depends on bfd_pkg; drives bfd_dp through bfd_cmd_t.
module bfd_ctrl
    import bfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    output bfd_cmd_t cmd,
    input  bfd_sts_t sts
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free    = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    // Outputs
    always_comb
    begin
        item_ready = (state_reg == CTL_IDLE);
        cmd.load   = (state_reg == CTL_IDLE) && item_valid;
        cmd.emit   = (state_reg != CTL_IDLE) && slot_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = sts.new_tick ? CTL_TICK : CTL_PKT;
                end
            end
            CTL_PKT:
            begin
                if (slot_free)
                begin
                    state_next = CTL_IDLE;
                end
            end
            CTL_TICK:
            begin
                if (slot_free && sts.at_last)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/bfd_dp.sv =====
// Datapath: configuration registers, per-port session table, one shared port
// update unit and the result register. Depends on bfd_pkg; sequenced by bfd_ctrl.
module bfd_dp
    import bfd_pkg::*;
#(
    parameter int PORT_COUNT = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  op,
    input  logic [7:0]            port,
    input  logic [47:0]           now_us,
    input  logic [31:0]           peer_discriminator,
    input  logic [7:0]            vers_and_diag,
    input  logic [15:0]           udp_length,
    input  logic [7:0]            link_down_mask,
    input  bfd_cmd_t              cmd,
    output bfd_sts_t              sts,
    output logic [7:0]            out_port,
    output logic [1:0]            kind,
    output logic                  send_echo,
    output logic                  went_down,
    output logic [1:0]            self_state,
    output logic [1:0]            peer_state,
    output logic [31:0]           remote_id,
    output logic [31:0]           change_count,
    output logic                  last
);

    localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    // Configuration
    logic [3:0]  ports_in_use_reg;
    logic [31:0] local_disc_reg;
    logic [7:0]  passive_mask_reg;
    logic [31:0] timeout_reg;
    logic [15:0] slow_ratio_reg;

    // Latched item
    logic              op_reg;
    logic [7:0]        port_reg;
    logic [TIME_W-1:0] now_reg;
    logic [31:0]       peer_reg;
    logic [7:0]        diag_reg;
    logic [15:0]       ulen_reg;
    logic [MASK_W-1:0] ldm_reg;
    logic [PW-1:0]     idx_reg;

    // Session table
    sess_state_t       ls_reg   [PORT_COUNT];
    sess_state_t       rs_reg   [PORT_COUNT];
    logic [7:0]        rdiag_reg[PORT_COUNT];
    logic [31:0]       rid_reg  [PORT_COUNT];
    logic [TIME_W-1:0] lrt_reg  [PORT_COUNT];
    logic [15:0]       skip_reg [PORT_COUNT];
    logic [31:0]       cnt_reg  [PORT_COUNT];

    // Result register
    logic [7:0]  res_port_reg;
    logic [1:0]  res_kind_reg;
    logic        res_echo_reg;
    logic        res_went_reg;
    logic [1:0]  res_ls_reg;
    logic [1:0]  res_rs_reg;
    logic [31:0] res_rid_reg;
    logic [31:0] res_cnt_reg;
    logic        res_last_reg;

    logic [5:0]        piu_w, n_w;
    logic              pkt_short, pkt_range, pkt_ok;
    logic [PW-1:0]     sel;
    logic [7:0]        sel8;
    sess_state_t       cur_ls, cur_rs;
    logic [31:0]       cur_rid, cur_cnt;
    logic [TIME_W-1:0] cur_lrt, elapsed;
    logic [15:0]       cur_skip;
    logic              ldm_bit, passive_bit, check, timed_out;
    sess_state_t       t_ls, t_rs;
    logic [31:0]       t_cnt;
    logic [15:0]       t_skip;
    logic              t_echo, t_went;
    logic [31:0]       p_rid;

    // Active port count: zero acts as one, clamp at the table depth
    assign piu_w = {2'b00, ports_in_use_reg};
    assign n_w   = (piu_w == 6'd0) ? 6'd1
                 : ((piu_w > 6'(PORT_COUNT)) ? 6'(PORT_COUNT) : piu_w);

    assign pkt_short = ulen_reg < MIN_UDP_LEN;
    assign pkt_range = port_reg >= {2'b00, n_w};
    assign pkt_ok    = !pkt_short && !pkt_range;

    assign sts.new_tick = op;
    assign sts.at_last  = (idx_reg == PW'(n_w - 6'd1));

    assign sel      = op_reg ? idx_reg : port_reg[PW-1:0];
    assign sel8     = 8'(sel);
    assign cur_ls   = ls_reg[sel];
    assign cur_rs   = rs_reg[sel];
    assign cur_rid  = rid_reg[sel];
    assign cur_cnt  = cnt_reg[sel];
    assign cur_lrt  = lrt_reg[sel];
    assign cur_skip = skip_reg[sel];

    // Masks only cover the first eight ports
    assign ldm_bit     = (sel8 < 8'(MASK_W)) ? ldm_reg[sel8[2:0]] : 1'b0;
    assign passive_bit = (sel8 < 8'(MASK_W)) ? passive_mask_reg[sel8[2:0]] : 1'b0;

    assign elapsed   = now_reg - cur_lrt;
    assign timed_out = elapsed > {16'h0000, timeout_reg};
    assign check     = !ldm_bit && (cur_rs == ST_UP) && !passive_bit;

    // Tick update of one port
    always_comb
    begin
        t_went = check && timed_out;
        t_rs   = t_went ? ST_DOWN : cur_rs;
        t_cnt  = cur_cnt + 32'(t_went);
        t_ls   = cur_ls;
        t_skip = cur_skip;
        t_echo = 1'b0;
        if (cur_ls != ST_ADMIN)
        begin
            t_ls = ST_UP;
            if (t_rs == ST_UP)
            begin
                t_echo = 1'b1;
            end
            else if (t_rs == ST_INIT || t_rs == ST_DOWN)
            begin
                if (cur_skip < slow_ratio_reg)
                begin
                    t_skip = cur_skip + 16'd1;
                end
                else
                begin
                    t_skip = 16'd0;
                    t_echo = 1'b1;
                end
            end
        end
    end

    assign p_rid = (cur_rs != ST_UP) ? peer_reg : cur_rid;

    // Configuration and latched item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ports_in_use_reg <= PORTS_IN_USE_RST;
            local_disc_reg   <= 32'd0;
            passive_mask_reg <= 8'd0;
            timeout_reg      <= TIMEOUT_RST;
            slow_ratio_reg   <= SLOW_RATIO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PORTS_IN_USE: ports_in_use_reg <= cfg_data[3:0];
                REG_LOCAL_DISC:   local_disc_reg   <= cfg_data;
                REG_PASSIVE_MASK: passive_mask_reg <= cfg_data[7:0];
                REG_TIMEOUT:      timeout_reg      <= cfg_data;
                REG_SLOW_RATIO:   slow_ratio_reg   <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            port_reg <= port;
            now_reg  <= now_us;
            peer_reg <= peer_discriminator;
            diag_reg <= vers_and_diag;
            ulen_reg <= udp_length;
            ldm_reg  <= link_down_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            idx_reg <= '0;
        end
        else if (cmd.emit && op_reg && !sts.at_last)
        begin
            idx_reg <= idx_reg + PW'(1);
        end
    end

    // Session table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                ls_reg[i]    <= ST_INIT;
                rs_reg[i]    <= ST_INIT;
                rdiag_reg[i] <= 8'd0;
                rid_reg[i]   <= 32'd0;
                lrt_reg[i]   <= '0;
                skip_reg[i]  <= 16'd0;
                cnt_reg[i]   <= 32'd0;
            end
        end
        else
        begin
            if (cfg_we && cfg_reg_t'(cfg_index) == REG_LOCAL_DISC)
            begin
                for (int i = 0; i < PORT_COUNT; i++)
                begin
                    rid_reg[i] <= cfg_data;
                end
            end
            if (cmd.emit)
            begin
                if (op_reg)
                begin
                    ls_reg[sel]   <= t_ls;
                    rs_reg[sel]   <= t_rs;
                    skip_reg[sel] <= t_skip;
                    cnt_reg[sel]  <= t_cnt;
                end
                else if (pkt_ok)
                begin
                    rs_reg[sel]    <= ST_UP;
                    rid_reg[sel]   <= p_rid;
                    rdiag_reg[sel] <= diag_reg;
                    lrt_reg[sel]   <= now_reg;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (op_reg)
            begin
                res_port_reg <= sel8;
                res_kind_reg <= KIND_TICK;
                res_echo_reg <= t_echo;
                res_went_reg <= t_went;
                res_ls_reg   <= t_ls;
                res_rs_reg   <= t_rs;
                res_rid_reg  <= cur_rid;
                res_cnt_reg  <= t_cnt;
                res_last_reg <= sts.at_last;
            end
            else
            begin
                res_port_reg <= port_reg;
                res_echo_reg <= 1'b0;
                res_went_reg <= 1'b0;
                res_last_reg <= 1'b1;
                if (pkt_ok)
                begin
                    res_kind_reg <= KIND_ACCEPTED;
                    res_ls_reg   <= cur_ls;
                    res_rs_reg   <= ST_UP;
                    res_rid_reg  <= p_rid;
                    res_cnt_reg  <= cur_cnt;
                end
                else
                begin
                    res_kind_reg <= pkt_short ? KIND_SHORT : KIND_RANGE;
                    res_ls_reg   <= 2'd0;
                    res_rs_reg   <= 2'd0;
                    res_rid_reg  <= 32'd0;
                    res_cnt_reg  <= 32'd0;
                end
            end
        end
    end

    assign out_port     = res_port_reg;
    assign kind         = res_kind_reg;
    assign send_echo    = res_echo_reg;
    assign went_down    = res_went_reg;
    assign self_state   = res_ls_reg;
    assign peer_state   = res_rs_reg;
    assign remote_id    = res_rid_reg;
    assign change_count = res_cnt_reg;
    assign last         = res_last_reg;

endmodule

// ===== rtl/bfd_session_liveness_monitor.sv =====
// Top level of the BFD session liveness monitor.
// Depends on bfd_pkg, bfd_if (channels), bfd_ctrl and bfd_dp.
//
// Per-port BFD session table with one item channel, one result channel and a
// configuration write channel. A received control packet is latched when it
// is accepted, then goes once through the shared port update unit into the
// result register, giving exactly one result. A checkpoint tick walks the N
// ports in use through the update unit one per cycle when not stalled, each
// step yielding one result, and the last one carries last = 1. A new item is
// accepted only once the previous one has produced all its results, but the
// result register decouples the two sides, so the next item may enter while
// the final result still waits. Backpressure on the result channel stalls the
// port walk. Configuration writes are always accepted (ready is tied high) and
// must only be issued while the block is idle; writing the local discriminator
// reloads the stored remote discriminator of every port.
module bfd_session_liveness_monitor
    import bfd_pkg::*;
#(
    parameter int PORT_COUNT = 8
)
(
    input logic       clk,
    input logic       rst_n,
    bfd_item_if.sink  item,
    bfd_result_if.source result,
    bfd_cfg_if.sink   cfg
);

    bfd_cmd_t cmd;
    bfd_sts_t sts;
    logic     cfg_we;

    // Configuration never stalls
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    bfd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    bfd_dp #(
        .PORT_COUNT (PORT_COUNT)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .op                 (item.op),
        .port               (item.port),
        .now_us             (item.now_us),
        .peer_discriminator (item.peer_discriminator),
        .vers_and_diag      (item.vers_and_diag),
        .udp_length         (item.udp_length),
        .link_down_mask     (item.link_down_mask),
        .cmd                (cmd),
        .sts                (sts),
        .out_port           (result.out_port),
        .kind               (result.kind),
        .send_echo          (result.send_echo),
        .went_down          (result.went_down),
        .self_state         (result.self_state),
        .peer_state         (result.peer_state),
        .remote_id          (result.remote_id),
        .change_count       (result.change_count),
        .last               (result.last)
    );

endmodule

// ===== rtl/bfd_checker.sv =====
// Port-level checks for the BFD session liveness monitor, bound to the top level.
// Depends on bfd_pkg for state and kind codes.
module bfd_checker
    import bfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  kind,
    input logic        went_down,
    input logic [1:0]  self_state,
    input logic [1:0]  peer_state,
    input logic [31:0] remote_id,
    input logic [31:0] change_count,
    input logic        last
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(kind) && $stable(last))
        else $error("stalled result changed");

    // One item at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while previous item in flight");

    // Packet results are single
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != KIND_TICK |-> last)
        else $error("packet result without last");

    // Rejected packets report a cleared session view
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_SHORT || kind == KIND_RANGE)
        |-> self_state == 2'd0 && peer_state == 2'd0
            && remote_id == 32'd0 && change_count == 32'd0)
        else $error("rejected packet with session fields");

    // A timeout only comes from a tick and leaves the remote Down
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && went_down |-> kind == KIND_TICK && peer_state == ST_DOWN)
        else $error("went_down without tick or Down state");

endmodule

bind bfd_session_liveness_monitor bfd_checker u_bfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .kind         (result.kind),
    .went_down    (result.went_down),
    .self_state   (result.self_state),
    .peer_state   (result.peer_state),
    .remote_id    (result.remote_id),
    .change_count (result.change_count),
    .last         (result.last)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the BFD session liveness monitor.
// Depends on bfd_pkg, the channel interfaces in bfd_if and the monitor top level.
`timescale 1ns / 1ps

module tb;
    import bfd_pkg::*;

    localparam int NPORTS = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int NUM_PHASES = 6;

    // One input item as it travels on the item channel.
    typedef struct {
        logic        op;
        logic [7:0]  port;
        logic [47:0] now_us;
        logic [31:0] peer_discriminator;
        logic [7:0]  vers_and_diag;
        logic [15:0] udp_length;
        logic [7:0]  link_down_mask;
    } bfd_item_t;

    // One result item as it leaves on the result channel.
    typedef struct {
        logic [7:0]   out_port;
        result_kind_t kind;
        logic         send_echo;
        logic         went_down;
        sess_state_t  self_state;
        sess_state_t  peer_state;
        logic [31:0]  remote_id;
        logic [31:0]  change_count;
        logic         last;
    } bfd_result_t;

    // Row of the directed table: either a register write or an item, and for a few
    // single-result packets the result written out by hand.
    typedef struct {
        bit          is_cfg;
        cfg_reg_t    reg_idx;
        logic [31:0] reg_val;
        bfd_item_t   item;
        bit          typed;
        bfd_result_t want;
    } dir_row_t;

    // Register settings of one random phase.
    typedef struct {
        logic [3:0]  ports;
        logic [31:0] disc;
        logic [7:0]  passive;
        logic [31:0] tmo;
        logic [15:0] ratio;
    } phase_t;

    logic clk;
    logic rst_n;

    bfd_item_if   item_ch ();
    bfd_result_if res_ch ();
    bfd_cfg_if    cfg_ch ();

    bfd_session_liveness_monitor #(.PORT_COUNT(NPORTS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Session table mirror: register copies and per-port state.
    logic [3:0]  m_ports;
    logic [31:0] m_disc;
    logic [7:0]  m_passive;
    logic [31:0] m_timeout;
    logic [15:0] m_ratio;
    sess_state_t loc_st   [NPORTS];
    sess_state_t rem_st   [NPORTS];
    logic [31:0] rem_id   [NPORTS];
    logic [47:0] rx_time  [NPORTS];
    logic [15:0] skip_cnt [NPORTS];
    logic [31:0] downs    [NPORTS];

    bfd_result_t expected_q [$];
    dir_row_t    dir_rows [$];

    int unsigned fail_cnt = 0;
    int unsigned snd_idle_pct = 19;
    int unsigned rcv_idle_pct = 88;
    logic        rcv_hold;
    logic        hold_go;

    // Free-running clock, 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("bfd_session_liveness_monitor: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Session table update for one accepted item. Compute every result the
    // item causes; push them to the expected queue unless the caller has its
    // own hand-written result for the row.
    // ---------------------------------------------------------------------
    function automatic void predict_item(input bfd_item_t it, input bit keep);
        int unsigned n;
        int unsigned p;
        logic [47:0] elapsed;
        bit          link_dn;
        bit          passive;
        bfd_result_t r;
        n = (m_ports == 4'd0) ? 1 : ((m_ports > NPORTS) ? NPORTS : m_ports);
        r.send_echo    = 1'b0;
        r.went_down    = 1'b0;
        r.self_state   = ST_ADMIN;
        r.peer_state   = ST_ADMIN;
        r.remote_id    = '0;
        r.change_count = '0;
        r.last         = 1'b1;
        if (it.op == 1'b0)
        begin
            r.out_port = it.port;
            p = it.port;
            // Length test comes ahead of the port test.
            if (it.udp_length < MIN_UDP_LEN)
                r.kind = KIND_SHORT;
            else if (p >= n)
                r.kind = KIND_RANGE;
            else
            begin
                // Capture the peer id only when coming up from a non-Up state.
                if (rem_st[p] != ST_UP)
                begin
                    rem_st[p] = ST_UP;
                    rem_id[p] = it.peer_discriminator;
                end
                rx_time[p]     = it.now_us;
                r.kind         = KIND_ACCEPTED;
                r.self_state   = loc_st[p];
                r.peer_state   = rem_st[p];
                r.remote_id    = rem_id[p];
                r.change_count = downs[p];
            end
            if (keep)
                expected_q.push_back(r);
            return;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            r.out_port  = 8'(i);
            r.kind      = KIND_TICK;
            r.send_echo = 1'b0;
            r.went_down = 1'b0;
            // Ports past the mask width are never passive and never link-down.
            link_dn = (i < MASK_W) && it.link_down_mask[i];
            passive = (i < MASK_W) && m_passive[i];
            if (!link_dn && !passive && rem_st[i] == ST_UP)
            begin
                elapsed = it.now_us - rx_time[i];
                if (elapsed > {16'd0, m_timeout})
                begin
                    rem_st[i]   = ST_DOWN;
                    downs[i]    = downs[i] + 32'd1;
                    r.went_down = 1'b1;
                end
            end
            if (loc_st[i] != ST_ADMIN)
            begin
                loc_st[i] = ST_UP;
                if (rem_st[i] == ST_UP)
                    r.send_echo = 1'b1;
                else if (rem_st[i] == ST_INIT || rem_st[i] == ST_DOWN)
                begin
                    // Slow probing: skip ticks while below the ratio.
                    if (skip_cnt[i] < m_ratio)
                        skip_cnt[i] = skip_cnt[i] + 16'd1;
                    else
                    begin
                        skip_cnt[i] = '0;
                        r.send_echo = 1'b1;
                    end
                end
            end
            r.self_state   = loc_st[i];
            r.peer_state   = rem_st[i];
            r.remote_id    = rem_id[i];
            r.change_count = downs[i];
            r.last         = (i + 1 == n);
            if (keep)
                expected_q.push_back(r);
        end
    endfunction

    // Directed table row builders.
    function automatic dir_row_t blank_row();
        dir_row_t r;
        r.is_cfg                  = 1'b0;
        r.reg_idx                 = REG_PORTS_IN_USE;
        r.reg_val                 = '0;
        r.item.op                 = 1'b0;
        r.item.port               = '0;
        r.item.now_us             = '0;
        r.item.peer_discriminator = '0;
        r.item.vers_and_diag      = '0;
        r.item.udp_length         = '0;
        r.item.link_down_mask     = '0;
        r.typed                   = 1'b0;
        r.want.out_port           = '0;
        r.want.kind               = KIND_ACCEPTED;
        r.want.send_echo          = 1'b0;
        r.want.went_down          = 1'b0;
        r.want.self_state         = ST_ADMIN;
        r.want.peer_state         = ST_ADMIN;
        r.want.remote_id          = '0;
        r.want.change_count       = '0;
        r.want.last               = 1'b1;
        return r;
    endfunction

    function automatic dir_row_t pkt_row(input logic [7:0] port, input logic [47:0] now,
                                         input logic [31:0] peer, input logic [7:0] diag,
                                         input logic [15:0] ulen);
        dir_row_t r;
        r = blank_row();
        r.item.port               = port;
        r.item.now_us             = now;
        r.item.peer_discriminator = peer;
        r.item.vers_and_diag      = diag;
        r.item.udp_length         = ulen;
        return r;
    endfunction

    function automatic dir_row_t tick_row(input logic [47:0] now, input logic [7:0] ldm);
        dir_row_t r;
        r = blank_row();
        r.item.op             = 1'b1;
        r.item.now_us         = now;
        r.item.link_down_mask = ldm;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input cfg_reg_t idx, input logic [31:0] val);
        dir_row_t r;
        r = blank_row();
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Attach a hand-written single result to a packet row.
    function automatic dir_row_t with_want(input dir_row_t r, input result_kind_t kind,
                                           input sess_state_t ls, input sess_state_t rs,
                                           input logic [31:0] rid);
        dir_row_t w;
        w = r;
        w.typed           = 1'b1;
        w.want.out_port   = r.item.port;
        w.want.kind       = kind;
        w.want.self_state = ls;
        w.want.peer_state = rs;
        w.want.remote_id  = rid;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Offer one item, with random idle cycles ahead of it, and hold it until taken.
    task automatic offer(input bfd_item_t it, input bit typed, input bfd_result_t want);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid              <= 1'b1;
        item_ch.op                 <= it.op;
        item_ch.port               <= it.port;
        item_ch.now_us             <= it.now_us;
        item_ch.peer_discriminator <= it.peer_discriminator;
        item_ch.vers_and_diag      <= it.vers_and_diag;
        item_ch.udp_length         <= it.udp_length;
        item_ch.link_down_mask     <= it.link_down_mask;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        predict_item(it, !typed);
        if (typed)
            expected_q.push_back(want);
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; leave valid high so back-to-back writes need no toggle.
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_PORTS_IN_USE: m_ports = val[3:0];
            REG_LOCAL_DISC:
            begin
                // Writing the local id reloads every stored remote id.
                m_disc = val;
                for (int i = 0; i < NPORTS; i++)
                    rem_id[i] = val;
            end
            REG_PASSIVE_MASK: m_passive = val[7:0];
            REG_TIMEOUT:      m_timeout = val;
            REG_SLOW_RATIO:   m_ratio   = val[15:0];
            default:          ;
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Result receiver: random ready, plus one long hold-off on request.
    // ---------------------------------------------------------------------
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
                res_ch.ready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Long stall on the result side, counted here, so the block backs up its input.
    initial
    begin
        rcv_hold <= 1'b0;
        wait (hold_go === 1'b1);
        @(posedge clk);
        rcv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rcv_hold <= 1'b0;
    end

    // ---------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest expectation.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        bfd_result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result on port %0d with nothing expected", res_ch.out_port);
                fail_cnt++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("out_port", 32'(want.out_port), 32'(res_ch.out_port));
                check_field("kind", 32'(want.kind), 32'(res_ch.kind));
                check_field("send_echo", 32'(want.send_echo), 32'(res_ch.send_echo));
                check_field("went_down", 32'(want.went_down), 32'(res_ch.went_down));
                check_field("self_state", 32'(want.self_state), 32'(res_ch.self_state));
                check_field("peer_state", 32'(want.peer_state),
                            32'(res_ch.peer_state));
                check_field("remote_id", want.remote_id, res_ch.remote_id);
                check_field("change_count", want.change_count, res_ch.change_count);
                check_field("last", 32'(want.last), 32'(res_ch.last));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus: reset, directed table, then random phases with new settings.
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        bfd_item_t   it;
        bfd_result_t none;
        dir_row_t    base_row;
        phase_t      phases [NUM_PHASES];
        logic [47:0] sim_now;
        int unsigned n;
        int unsigned step_max;
        int unsigned g;
        int unsigned sel;
        bit          cfg_open;

        // Drive every input to a known value and hold reset.
        rst_n                      <= 1'b0;
        hold_go                    <= 1'b0;
        item_ch.valid              <= 1'b0;
        item_ch.op                 <= 1'b0;
        item_ch.port               <= '0;
        item_ch.now_us             <= '0;
        item_ch.peer_discriminator <= '0;
        item_ch.vers_and_diag      <= '0;
        item_ch.udp_length         <= '0;
        item_ch.link_down_mask     <= '0;
        cfg_ch.valid               <= 1'b0;
        cfg_ch.index               <= REG_PORTS_IN_USE;
        cfg_ch.data                <= '0;

        // Mirror starts at the reset settings.
        m_ports   = PORTS_IN_USE_RST;
        m_disc    = '0;
        m_passive = '0;
        m_timeout = TIMEOUT_RST;
        m_ratio   = SLOW_RATIO_RST;
        for (int i = 0; i < NPORTS; i++)
        begin
            loc_st[i]   = ST_INIT;
            rem_st[i]   = ST_INIT;
            rem_id[i]   = '0;
            rx_time[i]  = '0;
            skip_cnt[i] = '0;
            downs[i]    = '0;
        end
        base_row = blank_row();
        none     = base_row.want;

        dir_rows = '{
            // First packets after reset: local still Init, peer id captured.
            with_want(pkt_row(8'd0, 48'd100, 32'hFFFF_FFFF, 8'hFF, 16'd24),
                      KIND_ACCEPTED, ST_INIT, ST_UP, 32'hFFFF_FFFF),
            with_want(pkt_row(8'd7, 48'd0, 32'h0, 8'h00, 16'hFFFF),
                      KIND_ACCEPTED, ST_INIT, ST_UP, 32'h0),
            // Too short, and too short on a bad port: length wins.
            with_want(pkt_row(8'd0, 48'd0, 32'h1234, 8'h5A, 16'd23),
                      KIND_SHORT, ST_ADMIN, ST_ADMIN, 32'h0),
            with_want(pkt_row(8'd255, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'd0),
                      KIND_SHORT, ST_ADMIN, ST_ADMIN, 32'h0),
            // Port out of range.
            with_want(pkt_row(8'd8, 48'd50, 32'h77, 8'h11, 16'd24),
                      KIND_RANGE, ST_ADMIN, ST_ADMIN, 32'h0),
            with_want(pkt_row(8'd255, 48'd50, 32'h77, 8'h11, 16'hFFFF),
                      KIND_RANGE, ST_ADMIN, ST_ADMIN, 32'h0),
            tick_row(48'd200, 8'h00),
            // All links down: no timeout even with huge elapsed time.
            tick_row(48'hFFFF_FFFF_FFFF, 8'hFF),
            // Ports 0 and 7 left up: both time out.
            tick_row(48'hFFFF_FFFF_FFFF, 8'h7E),
            pkt_row(8'd0, 48'hFFFF_FFFF_FF00, 32'h1234_5678, 8'h21, 16'd24),
            // Already up: stored id is kept.
            pkt_row(8'd0, 48'hFFFF_FFFF_FF00, 32'hAAAA_5555, 8'h20, 16'd24),
            // Elapsed time wraps through zero.
            tick_row(48'd256, 8'h00),
            cfg_row(REG_TIMEOUT, 32'd0),
            pkt_row(8'd3, 48'd500, 32'hCAFE_0003, 8'h03, 16'd24),
            // Zero elapsed against zero timeout stays up.
            tick_row(48'd500, 8'h00),
            cfg_row(REG_PASSIVE_MASK, 32'hFF),
            tick_row(48'd9000, 8'h00),
            cfg_row(REG_PASSIVE_MASK, 32'h00),
            // Ratio lowered under the skip counters: probes fire at once.
            cfg_row(REG_SLOW_RATIO, 32'd0),
            tick_row(48'd9001, 8'h00),
            cfg_row(REG_SLOW_RATIO, 32'hFFFF),
            tick_row(48'd9002, 8'h00),
            // Port count of zero acts as one.
            cfg_row(REG_PORTS_IN_USE, 32'd0),
            with_want(pkt_row(8'd1, 48'd9003, 32'h1, 8'h01, 16'd24),
                      KIND_RANGE, ST_ADMIN, ST_ADMIN, 32'h0),
            tick_row(48'd9004, 8'h00),
            // Port count above the table size acts as the table size.
            cfg_row(REG_PORTS_IN_USE, 32'd15),
            cfg_row(REG_LOCAL_DISC, 32'hFFFF_FFFF),
            tick_row(48'd9005, 8'h00)
        };

        phases = '{
            '{4'd8,  $urandom,     8'($urandom), 32'd3000,     16'd3},
            '{4'd3,  32'h0,        8'h00,        32'hFFFF_FFFF, 16'd0},
            '{4'd15, 32'hFFFF_FFFF, 8'hFF,       32'd40,        16'hFFFF},
            '{4'd1,  $urandom,     8'($urandom), 32'd0,         16'd1},
            '{4'd5,  $urandom,     8'hA5,        32'd500,       16'd2},
            '{4'd8,  $urandom,     8'h00,        32'd2500,      16'd10}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; writes only once the block has drained.
        cfg_open = 1'b0;
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_cfg)
            begin
                if (!cfg_open)
                    drain_results();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                    cfg_ch.valid <= 1'b0;
                cfg_open = 1'b0;
                offer(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // Random phases: new settings each time, mostly well-formed packets.
        sim_now = 48'd10_000;
        g = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_reg(REG_PORTS_IN_USE, 32'(phases[p].ports));
            write_reg(REG_LOCAL_DISC,   phases[p].disc);
            write_reg(REG_PASSIVE_MASK, 32'(phases[p].passive));
            write_reg(REG_TIMEOUT,      phases[p].tmo);
            write_reg(REG_SLOW_RATIO,   32'(phases[p].ratio));
            cfg_ch.valid <= 1'b0;
            n = (m_ports == 4'd0) ? 1 : ((m_ports > NPORTS) ? NPORTS : m_ports);
            step_max = (m_timeout < 32'd2000) ? m_timeout + 1 : 2000;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Idle pattern: sender light / receiver heavy, then swapped, then none.
                if (g < 100)
                begin
                    snd_idle_pct = 19;
                    rcv_idle_pct = 88;
                end
                else if (g < 200)
                begin
                    snd_idle_pct = 88;
                    rcv_idle_pct = 19;
                end
                else
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
                if (g == 280)
                    hold_go <= 1'b1;

                // Advance time mostly in small steps; now and then jump or near-wrap.
                sel = $urandom_range(0, 39);
                if (sel == 0)
                    sim_now = {16'($urandom), 32'($urandom)};
                else if (sel == 1)
                    sim_now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 2000));
                else
                    sim_now = sim_now + 48'($urandom_range(0, step_max));

                it.op                 = ($urandom_range(0, 99) < 22);
                it.port               = 8'($urandom_range(0, n - 1));
                it.now_us             = sim_now;
                it.peer_discriminator = $urandom;
                it.vers_and_diag      = 8'($urandom);
                it.udp_length         = 16'($urandom_range(24, 65535));
                it.link_down_mask     = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
                if (it.op)
                    it.port = 8'($urandom);
                else
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 10)
                        it.udp_length = 16'($urandom_range(0, 23));
                    else if (sel < 20)
                        it.port = 8'($urandom_range(n, 255));
                end
                offer(it, 1'b0, none);
                g++;
            end
        end

        // Let the last results drain, then idle before reporting.
        drain_results();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && expected_q.size() == 0)
            $display("bfd_session_liveness_monitor: match");
        else
            $display("bfd_session_liveness_monitor: mismatch");
        $finish;
    end

endmodule
